/* src/mmq_pkg.sv */
// package for the mailbox message queue pool
// holds sizes, request codes, fsm states; no dependencies
package mmq_pkg;
  localparam int MsgSlots    = 64;
  localparam int ThreadSlots = 32;
  localparam int ValueWidth  = 32;
  localparam int LinkW       = $clog2(MsgSlots + 1);
  localparam int SlotW       = $clog2(MsgSlots);
  localparam int ThrW        = $clog2(ThreadSlots);
  localparam logic [LinkW-1:0] LinkNone = LinkW'(MsgSlots);

  typedef enum logic [1:0] {
    ReqAdd    = 2'd0,
    ReqGetAny = 2'd1,
    ReqGetPeer = 2'd2,
    ReqBad    = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    StInit, StIdle, StRdQ, StAddWr, StGetRd, StGetChk, StGetUnlink,
    StGetTail, StOut
  } state_e;
endpackage

/* src/mailbox_message_queue_pool.sv */
// top level of the mailbox message queue pool
// depends on mmq_pkg; slot and queue stores are local memories
//
// usage: one request word on s_axis, one result word on m_axis per request.
// s_axis_tdata (lsb up): req_type[1:0], dest_thread[6:2], dest_present[7],
//   peer_thread[12:8], peer_present[13], payload_in[45:14], zero fill to 48.
// m_axis_tdata (lsb up): status[0], payload_out[32:1], sender_out[37:33],
//   zero fill to 40.
// one request is worked at a time. an add reads the queue, writes the slot, then
// links it into the queue and gives its result; an unfiltered get reads the
// queue, reads and checks the head slot, unlinks it, returns it to the free list
// and gives its result. a failed add or a bad request gives its result after the
// queue read, a get on an empty queue once the empty head is seen. a filtered get
// adds one more read of the slot memory and check per queue entry that does not
// match, up to MsgSlots entries. after reset a pass over all MsgSlots slots
// chains the free list in the link memory; no request is taken until it ends.
// the result sits in an output register; while the receiver stalls the block
// holds it and takes no new request.
module mailbox_message_queue_pool (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // req_type, dest_thread, dest_present,
                                     // peer_thread, peer_present, payload_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // status, payload_out, sender_out
);
  import mmq_pkg::*;

  // slot memory and queue memory
  logic [ThrW-1:0]       snd_mem [MsgSlots];
  logic [ValueWidth-1:0] val_mem [MsgSlots];
  logic [LinkW-1:0]      lnk_mem [MsgSlots];
  logic [2*LinkW-1:0]    q_mem   [ThreadSlots];

  state_e state_q, state_d;
  logic [SlotW:0] init_q;
  logic [LinkW-1:0] free_q, cur_q, prev_q, head_q, tail_q, nxt_q;
  logic [SlotW:0] n_q;
  logic [1:0] req_q;
  logic [ThrW-1:0] dest_q, peer_q;
  logic ok_q, qv_q;
  logic [ValueWidth-1:0] pay_q;
  logic [ThrW-1:0] rs_snd;
  logic [ValueWidth-1:0] rs_val;
  logic [LinkW-1:0] rs_lnk;
  logic [2*LinkW-1:0] rq;
  logic st_q;
  logic [31:0] po_q;
  logic [4:0] so_q;

  // slot address for reads: free head while the queue is read, else the walked slot
  logic [SlotW-1:0] rd_addr;
  assign rd_addr = (state_q == StRdQ) ? free_q[SlotW-1:0] : cur_q[SlotW-1:0];

  // queue address for reads: incoming destination while idle
  logic [ThrW-1:0] q_addr;
  assign q_addr = (state_q == StIdle) ? s_axis_tdata[6:2] : dest_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StInit:  if (init_q == (SlotW+1)'(MsgSlots - 1)) state_d = StIdle;
      StIdle:  if (s_axis_tvalid) state_d = StRdQ;
      StRdQ:   state_d = !ok_q ? StOut : (req_q == ReqAdd) ? StAddWr : StGetRd;
      StAddWr: state_d = StOut;
      StGetRd: state_d = (cur_q >= LinkNone) ? StOut : StGetChk;
      StGetChk: begin
        if (req_q != ReqGetPeer || rs_snd == peer_q) state_d = StGetUnlink;
        else if (n_q == (SlotW+1)'(MsgSlots - 1)) state_d = StOut;
        else state_d = StGetRd;
      end
      StGetUnlink: state_d = StGetTail;
      StGetTail: state_d = StOut;
      StOut:   if (m_axis_tready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready = (state_q == StIdle);
    m_axis_tvalid = (state_q == StOut);
    m_axis_tdata  = {2'b0, so_q, po_q, st_q};
  end

  // memory reads, registered
  always_ff @(posedge clk_i) begin
    rs_snd <= snd_mem[rd_addr];
    rs_val <= val_mem[rd_addr];
    rs_lnk <= lnk_mem[rd_addr];
    rq     <= q_mem[q_addr];
  end

  // link memory writes, and the sender and value writes of an add
  always_ff @(posedge clk_i) begin
    if (state_q == StInit) begin
      lnk_mem[init_q[SlotW-1:0]] <= LinkW'(init_q) + LinkW'(1);
    end else if (state_q == StRdQ && ok_q && req_q == ReqAdd) begin
      lnk_mem[free_q[SlotW-1:0]] <= LinkNone;
      snd_mem[free_q[SlotW-1:0]] <= peer_q;
      val_mem[free_q[SlotW-1:0]] <= pay_q;
    end else if (state_q == StAddWr && rq[LinkW-1:0] < LinkNone) begin
      lnk_mem[rq[SlotW-1:0]] <= cur_q;
    end else if (state_q == StGetUnlink && prev_q < LinkNone) begin
      lnk_mem[prev_q[SlotW-1:0]] <= nxt_q;
    end else if (state_q == StGetTail) begin
      lnk_mem[rd_addr] <= free_q;
    end
  end

  // queue memory writes, head in upper half, tail in lower half
  always_ff @(posedge clk_i) begin
    if (state_q == StAddWr) begin
      q_mem[dest_q] <= {(rq[LinkW-1:0] < LinkNone) ? rq[2*LinkW-1:LinkW] : cur_q, cur_q};
    end else if (state_q == StGetUnlink) begin
      q_mem[dest_q] <= {(prev_q < LinkNone) ? head_q : nxt_q,
                        (tail_q == cur_q) ? prev_q : tail_q};
    end else if (!qv_q) begin
      q_mem[dest_q] <= {LinkNone, LinkNone};
    end
  end

  // control and payload registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StInit;
      init_q  <= '0;
      free_q  <= '0;
      qv_q    <= 1'b0;
      dest_q  <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        StInit: begin
          init_q <= init_q + 1'b1;
          dest_q <= ThrW'(init_q);
          qv_q   <= (init_q >= (SlotW+1)'(ThreadSlots));
        end
        StIdle: if (s_axis_tvalid) begin
          req_q  <= s_axis_tdata[1:0];
          dest_q <= s_axis_tdata[6:2];
          peer_q <= s_axis_tdata[12:8];
          pay_q  <= s_axis_tdata[45:14];
          ok_q   <= (s_axis_tdata[1:0] != ReqBad) &&
                    (s_axis_tdata[1:0] != ReqAdd ||
                     (s_axis_tdata[7] && s_axis_tdata[13] && free_q < LinkNone));
          if (s_axis_tdata[1:0] == ReqGetPeer && !s_axis_tdata[13])
            req_q <= ReqGetAny;
          st_q <= 1'b1; po_q <= '0; so_q <= '0;
        end
        StRdQ: begin
          head_q <= rq[2*LinkW-1:LinkW];
          tail_q <= rq[LinkW-1:0];
          prev_q <= LinkNone;
          n_q    <= '0;
          if (req_q == ReqAdd) begin
            cur_q <= free_q;
            if (ok_q) st_q <= 1'b0;
          end else cur_q <= rq[2*LinkW-1:LinkW];
        end
        StAddWr: free_q <= rs_lnk;
        StGetChk: begin
          nxt_q <= rs_lnk;
          if (!(req_q != ReqGetPeer || rs_snd == peer_q)) begin
            prev_q <= cur_q;
            cur_q  <= rs_lnk;
            n_q    <= n_q + 1'b1;
          end else begin
            st_q <= 1'b0; po_q <= rs_val; so_q <= rs_snd;
          end
        end
        StGetTail: free_q <= cur_q;
        default: ;
      endcase
    end
  end

  // checks
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("both sides open");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[37:1] == '0)
    else $error("failure carries data");
endmodule

/* tb/mailbox_message_queue_pool_checker.sv */
// checker for the mailbox message queue pool: watches both streams,
// predicts each result word and compares it; depends on mmq_pkg
module mailbox_message_queue_pool_checker
  import mmq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  output int          errors_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                  status;
    logic [ValueWidth-1:0] payload;
    logic [ThrW-1:0]       sender;
  } mbox_result_t;

  // shadow copy of the pool
  logic [ThrW-1:0]       pool_sender [MsgSlots];
  logic [ValueWidth-1:0] pool_value  [MsgSlots];
  int                    pool_link   [MsgSlots];
  int                    mbox_head   [ThreadSlots];
  int                    mbox_tail   [ThreadSlots];
  int                    free_top;

  mbox_result_t expected_words[$];
  int           errors;

  assign errors_o  = errors;
  assign pending_o = expected_words.size();

  function automatic mbox_result_t serve_request(logic [47:0] w);
    mbox_result_t r;
    req_e                  kind;
    int                    dest, peer, s, prev, cur, n;
    logic                  dest_ok, peer_ok;
    kind    = req_e'(w[1:0]);
    dest    = w[6:2];
    dest_ok = w[7];
    peer    = w[12:8];
    peer_ok = w[13];
    r       = '0;
    r.status = 1'b1;
    if (dest >= ThreadSlots || kind == ReqBad) return r;
    if (kind == ReqAdd) begin
      if (!peer_ok || !dest_ok || peer >= ThreadSlots || free_top >= MsgSlots) return r;
      s = free_top;
      free_top = pool_link[s];
      pool_sender[s] = ThrW'(peer);
      pool_value[s]  = w[45:14];
      pool_link[s]   = MsgSlots;
      if (mbox_tail[dest] < MsgSlots) pool_link[mbox_tail[dest]] = s;
      else mbox_head[dest] = s;
      mbox_tail[dest] = s;
      r.status = 1'b0;
      return r;
    end
    if (kind == ReqGetPeer && !peer_ok) kind = ReqGetAny;
    prev = MsgSlots;
    cur  = mbox_head[dest];
    if (kind == ReqGetPeer) begin
      n = 0;
      while (cur < MsgSlots && n < MsgSlots && pool_sender[cur] != peer) begin
        prev = cur;
        cur  = pool_link[cur];
        n++;
      end
      if (n >= MsgSlots) cur = MsgSlots;
    end
    if (cur >= MsgSlots) return r;
    if (prev < MsgSlots) pool_link[prev] = pool_link[cur];
    else mbox_head[dest] = pool_link[cur];
    if (mbox_tail[dest] == cur) mbox_tail[dest] = prev;
    r.status  = 1'b0;
    r.payload = pool_value[cur];
    r.sender  = pool_sender[cur];
    pool_link[cur] = free_top;
    free_top = cur;
    return r;
  endfunction

  // predict on accepted requests, compare on accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    mbox_result_t got, want;
    if (!rst_ni) begin
      for (int i = 0; i < MsgSlots; i++) begin
        pool_link[i] = i + 1;
        pool_sender[i] = '0;
        pool_value[i] = '0;
      end
      for (int i = 0; i < ThreadSlots; i++) begin
        mbox_head[i] = MsgSlots;
        mbox_tail[i] = MsgSlots;
      end
      free_top = 0;
      expected_words.delete();
      errors = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_words.push_back(serve_request(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got.status  = m_axis_tdata[0];
        got.payload = m_axis_tdata[32:1];
        got.sender  = m_axis_tdata[37:33];
        if (expected_words.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result word %h", m_axis_tdata);
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("result word: expected st=%0b val=%h snd=%0d, got st=%0b val=%h snd=%0d",
                       want.status, want.payload, want.sender,
                       got.status, got.payload, got.sender);
          end
        end
      end
    end
  end
endmodule

/* tb/mailbox_message_queue_pool_tb.sv */
// top of the mailbox message queue pool testbench: clock, reset, stimulus,
// verdict; depends on mmq_pkg, the block and the checker module
module mailbox_message_queue_pool_tb;
  import mmq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  int          errors, pending;
  int          sent;
  bit          quiet_phase = 1'b0;
  bit          hold_sink = 1'b0;
  int          idle_cycles = 0;

  mailbox_message_queue_pool dut (.*);

  mailbox_message_queue_pool_checker chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [47:0] pack_request(req_e kind, int dest, bit dok, int peer,
                                               bit pok, logic [31:0] val);
    return {2'b0, val, pok, 5'(peer), dok, 5'(dest), kind};
  endfunction

  // present one request word, with random gaps before it
  task automatic send_word(logic [47:0] w);
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent++;
  endtask

  // mostly adds and gets on a few threads so queues fill and senders repeat
  task automatic send_random();
    int          r, dest, peer;
    req_e        kind;
    r = $urandom_range(0, 99);
    kind = r < 50 ? ReqAdd : r < 72 ? ReqGetAny : r < 97 ? ReqGetPeer : ReqBad;
    dest = $urandom_range(0, 9) == 0 ? $urandom_range(0, 31) : $urandom_range(0, 3);
    peer = $urandom_range(0, 9) == 0 ? $urandom_range(0, 31) : $urandom_range(0, 3);
    send_word(pack_request(kind, dest, $urandom_range(0, 15) != 0, peer,
                           $urandom_range(0, 15) != 0, $urandom()));
  endtask

  // receiver: random stall bursts, one long hold-off, none at the end
  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_sink = 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("mailbox_message_queue_pool: mismatch");
      $finish;
    end
  end

  initial begin
    sent = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: field extremes, null sender and destination, every request kind
    send_word(pack_request(ReqGetAny, 0, 1, 0, 1, '0));
    send_word(pack_request(ReqGetPeer, 31, 1, 31, 1, '0));
    send_word(pack_request(ReqBad, 31, 1, 31, 1, '1));
    send_word(pack_request(ReqAdd, 0, 0, 1, 1, 32'h1234));
    send_word(pack_request(ReqAdd, 0, 1, 1, 0, 32'h1234));
    send_word(pack_request(ReqAdd, 31, 1, 31, 1, '1));
    send_word(pack_request(ReqAdd, 31, 1, 0, 1, '0));
    send_word(pack_request(ReqAdd, 31, 1, 5, 1, 32'hA5A5_5A5A));
    send_word(pack_request(ReqGetPeer, 31, 0, 5, 1, '0));
    send_word(pack_request(ReqGetPeer, 31, 1, 9, 1, '0));
    send_word(pack_request(ReqGetPeer, 31, 1, 9, 0, '0));
    send_word(pack_request(ReqGetAny, 31, 0, 0, 0, '1));
    send_word(pack_request(ReqGetAny, 31, 1, 0, 1, '0));
    // exhaust the pool then fail one more add, then drain by filter
    for (int i = 0; i < MsgSlots + 1; i++)
      send_word(pack_request(ReqAdd, 2, 1, i % 3, 1, $urandom()));
    for (int i = 0; i < MsgSlots + 1; i++)
      send_word(pack_request(ReqGetPeer, 2, 1, 2 - (i % 3), 1, '0));
    // pressure: receiver holds off while requests keep coming
    hold_sink = 1'b1;
    for (int i = 0; i < 20; i++) send_random();
    for (int i = 0; i < 850; i++) send_random();
    quiet_phase = 1'b1;
    for (int i = 0; i < 60; i++) send_random();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0)
      $display("mailbox_message_queue_pool: match");
    else
      $display("mailbox_message_queue_pool: mismatch");
    $finish;
  end
endmodule

/* files.f */
src/mmq_pkg.sv
src/mailbox_message_queue_pool.sv
tb/mailbox_message_queue_pool_checker.sv
tb/mailbox_message_queue_pool_tb.sv
